>>> sv/sibc_pkg.sv
// ----------------------------------------------------------------------------
// sibc_pkg
// Types and constants shared by the shape-in-box check unit.
// ----------------------------------------------------------------------------
package sibc_pkg;

   localparam int PT_W    = 18;  // point coordinate width
   localparam int TOTAL_W = 26;  // running sum width
   localparam int COUNT_W = 8;   // point count width
   localparam int REG_W   = 12;  // box register width
   localparam int IDX_W   = 2;   // register index width

   localparam logic signed [PT_W-1:0] PT_MOST_NEG = {1'b1, {(PT_W-1){1'b0}}};
   localparam logic signed [PT_W-1:0] PT_MOST_POS = {1'b0, {(PT_W-1){1'b1}}};

   typedef enum logic [IDX_W-1:0] {
      REG_BOX_LEFT   = 2'd0,
      REG_BOX_TOP    = 2'd1,
      REG_BOX_WIDTH  = 2'd2,
      REG_BOX_HEIGHT = 2'd3
   } reg_index_type;

   // Box geometry as held in the register bank
   typedef struct packed {
      logic [REG_W-1:0] left;
      logic [REG_W-1:0] top;
      logic [REG_W-1:0] width;
      logic [REG_W-1:0] height;
   } box_cfg_type;

   // Summary of one finished shape, handed from front to back
   typedef struct packed {
      logic signed [PT_W-1:0]    min_x;
      logic signed [PT_W-1:0]    max_x;
      logic signed [PT_W-1:0]    min_y;
      logic signed [PT_W-1:0]    max_y;
      logic signed [TOTAL_W-1:0] total_x;
      logic signed [TOTAL_W-1:0] total_y;
      logic [COUNT_W-1:0]        count;
   } shape_sums_type;

endpackage

>>> sv/sibc_front.sv
// ----------------------------------------------------------------------------
// sibc_front
// Accepts point beats and keeps running min, max, sum and count per shape.
// ----------------------------------------------------------------------------
module sibc_front import sibc_pkg::*; #(
   parameter int MAX_POINTS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [PT_W-1:0] point_x,
   input  logic signed [PT_W-1:0] point_y,
   input  logic                   last_point,
   input  logic                   queue_full,
   output logic                   push,
   output shape_sums_type         push_data
);

   shape_sums_type acc_ff, acc_in, upd;
   logic           accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      upd = acc_ff;
      if (point_x > acc_ff.max_x) upd.max_x = point_x;
      if (point_x < acc_ff.min_x) upd.min_x = point_x;
      if (point_y > acc_ff.max_y) upd.max_y = point_y;
      if (point_y < acc_ff.min_y) upd.min_y = point_y;
      // sums and count freeze at the bound; min and max keep tracking
      if (acc_ff.count < COUNT_W'(MAX_POINTS)) begin
         upd.total_x = acc_ff.total_x + TOTAL_W'(point_x);
         upd.total_y = acc_ff.total_y + TOTAL_W'(point_y);
         upd.count   = acc_ff.count + COUNT_W'(1);
      end

      acc_in = acc_ff;
      if (accept) begin
         if (last_point) begin
            acc_in.min_x   = PT_MOST_POS;
            acc_in.max_x   = PT_MOST_NEG;
            acc_in.min_y   = PT_MOST_POS;
            acc_in.max_y   = PT_MOST_NEG;
            acc_in.total_x = '0;
            acc_in.total_y = '0;
            acc_in.count   = '0;
         end else begin
            acc_in = upd;
         end
      end
   end

   assign push      = accept && last_point;
   assign push_data = upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.min_x   <= PT_MOST_POS;
         acc_ff.max_x   <= PT_MOST_NEG;
         acc_ff.min_y   <= PT_MOST_POS;
         acc_ff.max_y   <= PT_MOST_NEG;
         acc_ff.total_x <= '0;
         acc_ff.total_y <= '0;
         acc_ff.count   <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

>>> sv/sibc_queue.sv
// ----------------------------------------------------------------------------
// sibc_queue
// Two-entry queue of shape summaries between front and back.
// ----------------------------------------------------------------------------
module sibc_queue import sibc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  shape_sums_type push_data,
   input  logic           pop,
   output logic           not_empty,
   output logic           full,
   output shape_sums_type head
);

   localparam int DEPTH = 2;

   shape_sums_type slot_ff [DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;
   logic           do_pop;

   assign not_empty = (fill_ff != 2'd0);
   assign full      = (fill_ff == 2'(DEPTH));
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> sv/sibc_back.sv
// ----------------------------------------------------------------------------
// sibc_back
// Runs spread and centre tests on one shape summary; holds the result beat.
// ----------------------------------------------------------------------------
module sibc_back import sibc_pkg::*; #(
   parameter int FRACTION_BITS = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  box_cfg_type    box,
   input  logic           not_empty,
   input  shape_sums_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           shape_inside
);

   localparam int SPR_W  = PT_W + 1;
   localparam int CEN_W  = REG_W + 2;
   localparam int PROD_W = COUNT_W + CEN_W;
   localparam int SCL_W  = PROD_W + FRACTION_BITS;
   localparam int DIFF_W = ((SCL_W > TOTAL_W + 1) ? SCL_W : TOTAL_W + 1) + 1;
   localparam int CMP_W  = ((SPR_W + 1 > CEN_W + FRACTION_BITS) ?
                            SPR_W + 1 : CEN_W + FRACTION_BITS) + 1;

   logic advance;

   // stage A: spreads and products
   logic                      a_valid_ff;
   logic [SPR_W-1:0]          a_spr_x_ff, a_spr_y_ff;
   logic [PROD_W-1:0]         a_cen_x_ff, a_cen_y_ff, a_lim_x_ff, a_lim_y_ff;
   logic signed [TOTAL_W-1:0] a_tot_x_ff, a_tot_y_ff;
   logic [SPR_W-1:0]          a_spr_x_in, a_spr_y_in;
   logic [CEN_W-1:0]          cen_x, cen_y;

   // stage B: spread verdicts and signed offsets
   logic                     b_valid_ff, b_spr_ok_ff;
   logic signed [DIFF_W-1:0] b_diff_x_ff, b_diff_y_ff, b_diff_x_in, b_diff_y_in;
   logic [SCL_W-1:0]         b_lim_x_ff, b_lim_y_ff;
   logic                     b_spr_ok_in;

   // stage C and output register
   logic                     rsp_valid_ff, shape_inside_ff, shape_inside_in;
   logic [DIFF_W-1:0]        abs_x, abs_y;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign pop       = advance && not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign shape_inside = shape_inside_ff;

   always_comb begin
      a_spr_x_in = {head.max_x[PT_W-1], head.max_x} - {head.min_x[PT_W-1], head.min_x};
      a_spr_y_in = {head.max_y[PT_W-1], head.max_y} - {head.min_y[PT_W-1], head.min_y};
      cen_x = {1'b0, box.left, 1'b0} + CEN_W'(box.width);
      cen_y = {1'b0, box.top, 1'b0} + CEN_W'(box.height);
   end

   always_comb begin
      b_spr_ok_in =
         (CMP_W'({a_spr_x_ff, 1'b0}) <=
          (CMP_W'(3) * CMP_W'(box.width)) << FRACTION_BITS) &&
         (CMP_W'({a_spr_y_ff, 1'b0}) <=
          (CMP_W'(3) * CMP_W'(box.height)) << FRACTION_BITS);
      // sums are signed: widen with sign before doubling
      b_diff_x_in = (DIFF_W'(a_tot_x_ff) <<< 1) -
                    $signed(DIFF_W'(a_cen_x_ff) << FRACTION_BITS);
      b_diff_y_in = (DIFF_W'(a_tot_y_ff) <<< 1) -
                    $signed(DIFF_W'(a_cen_y_ff) << FRACTION_BITS);
   end

   always_comb begin
      abs_x = b_diff_x_ff[DIFF_W-1] ? DIFF_W'(-b_diff_x_ff) : DIFF_W'(b_diff_x_ff);
      abs_y = b_diff_y_ff[DIFF_W-1] ? DIFF_W'(-b_diff_y_ff) : DIFF_W'(b_diff_y_ff);
      shape_inside_in = b_spr_ok_ff &&
                        (abs_x <= DIFF_W'(b_lim_x_ff)) &&
                        (abs_y <= DIFF_W'(b_lim_y_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= not_empty;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_spr_x_ff  <= a_spr_x_in;
         a_spr_y_ff  <= a_spr_y_in;
         a_cen_x_ff  <= PROD_W'(head.count) * PROD_W'(cen_x);
         a_cen_y_ff  <= PROD_W'(head.count) * PROD_W'(cen_y);
         a_lim_x_ff  <= PROD_W'(head.count) * PROD_W'(box.width);
         a_lim_y_ff  <= PROD_W'(head.count) * PROD_W'(box.height);
         a_tot_x_ff  <= head.total_x;
         a_tot_y_ff  <= head.total_y;
         b_spr_ok_ff <= b_spr_ok_in;
         b_diff_x_ff <= b_diff_x_in;
         b_diff_y_ff <= b_diff_y_in;
         b_lim_x_ff  <= SCL_W'(a_lim_x_ff) << FRACTION_BITS;
         b_lim_y_ff  <= SCL_W'(a_lim_y_ff) << FRACTION_BITS;
         shape_inside_ff <= shape_inside_in;
      end
   end

endmodule

>>> sv/shape_in_box_check_unit.sv
// ----------------------------------------------------------------------------
// shape_in_box_check_unit
// Checks whether a streamed landmark shape fits a candidate face box.
// ----------------------------------------------------------------------------
// Throughput: one point beat per cycle while req_stall is low, shapes back to back.
// The summary of a shape is written into the queue on the edge that accepts
//   its last point beat, then passes the multiply, offset and compare stages
//   of the back end.
// A held result stalls the back end; the two-entry queue then fills and
//   req_stall rises only once both entries are taken.
// Reset (synchronous): box regs to left 0, top 0, width 1, height 1;
//   shape state cleared, queue and pipeline emptied.
module shape_in_box_check_unit import sibc_pkg::*; #(
   parameter int MAX_POINTS    = 128,
   parameter int FRACTION_BITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // point beats
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [PT_W-1:0] req_point_x,
   input  logic signed [PT_W-1:0] req_point_y,
   input  logic                   req_last_point,
   // result beats
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_shape_inside,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [REG_W-1:0]       csr_data
);

   box_cfg_type    box_ff, box_in;
   logic           push, pop, q_full, q_not_empty;
   shape_sums_type push_data, head;

   // register bank: writes always taken, only while idle by contract
   assign csr_ready = 1'b1;

   always_comb begin
      box_in = box_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_BOX_LEFT:   box_in.left   = csr_data;
            REG_BOX_TOP:    box_in.top    = csr_data;
            REG_BOX_WIDTH:  box_in.width  = csr_data;
            REG_BOX_HEIGHT: box_in.height = csr_data;
            default:        box_in = box_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.left   <= '0;
         box_ff.top    <= '0;
         box_ff.width  <= REG_W'(1);
         box_ff.height <= REG_W'(1);
      end else begin
         box_ff <= box_in;
      end
   end

   // front: per-beat min/max/sum update, summary pushed on the last beat
   sibc_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .last_point (req_last_point),
      .queue_full (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decoupling queue
   sibc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (head)
   );

   // back: exact cross-multiplied tests, result register
   sibc_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .box          (box_ff),
      .not_empty    (q_not_empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .shape_inside (rsp_shape_inside)
   );

endmodule

>>> sv/sibc_checker.sv
// ----------------------------------------------------------------------------
// sibc_checker
// Port-level assertions for the shape-in-box check unit.
// ----------------------------------------------------------------------------
module sibc_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_shape_inside
);

   // held result beat keeps its flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shape_inside))
      else $error("result beat changed while stalled");

   // out of reset nothing pending and input open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // with no held result the back end drains, so the queue cannot stay full
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !req_stall)
      else $error("input stalled without a held result");

endmodule

bind shape_in_box_check_unit sibc_checker u_sibc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_shape_inside (rsp_shape_inside)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - shape_in_box_check_unit
// Streams landmark shapes into the unit and scores every shape_inside flag
// against an in-bench prediction of the box tests (spread and mean, exact
// integer form). Directed shapes first, then random shapes under random box
// settings with the sender idling, the receiver stalling, both, and neither.
// ----------------------------------------------------------------------------
module testbench;
   import sibc_pkg::*;

   localparam int MAX_PTS        = 128;
   localparam int FRAC_BITS      = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 8;    // covers the result pipeline, plus margin
   localparam int HOLD_CYCLES    = 80;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000; // cycles with no beat on any channel
   localparam int RANDOM_BEATS   = 35;   // least point beats queued per random phase

   typedef struct {
      logic signed [PT_W-1:0] x;
      logic signed [PT_W-1:0] y;
      logic                   last;
      bit                     wait_drain; // hold back until no verdict is due
   } landmark_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [PT_W-1:0] req_point_x = '0;
   logic signed [PT_W-1:0] req_point_y = '0;
   logic                   req_last_point = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_shape_inside;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [IDX_W-1:0]       csr_index = '0;
   logic [REG_W-1:0]       csr_data = '0;

   // stimulus store and handshake bookkeeping
   landmark_beat_type landmarks_pending[$];
   bit                fit_verdicts_due[$];
   logic              point_taken = 1'b0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   bit                hold_request = 1'b0;
   int                hold_left = 0;
   int                quiet_cycles = 0;

   // predicted register bank and running shape state
   box_cfg_type               box_now = '{left: '0, top: '0, width: 12'd1, height: 12'd1};
   logic signed [PT_W-1:0]    hi_x = PT_MOST_NEG;
   logic signed [PT_W-1:0]    lo_x = PT_MOST_POS;
   logic signed [PT_W-1:0]    hi_y = PT_MOST_NEG;
   logic signed [PT_W-1:0]    lo_y = PT_MOST_POS;
   logic signed [TOTAL_W-1:0] tot_x = '0;
   logic signed [TOTAL_W-1:0] tot_y = '0;
   logic [COUNT_W-1:0]        pts_held = '0;

   // run statistics
   int mismatches = 0;
   int points_accepted = 0;
   int verdicts_checked = 0;
   int inside_seen = 0;
   int box_settings = 1;

   shape_in_box_check_unit #(
      .MAX_POINTS    (MAX_PTS),
      .FRACTION_BITS (FRAC_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_shape_inside (rsp_shape_inside),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // One axis of the box test. Both halves are exact: the spread test is
   // 2*spread <= 3*size*2^F and the mean test cross-multiplies by the count,
   // |2*total - n*(2*origin+size)*2^F| <= n*size*2^F.
   function automatic bit axis_within_box(input logic signed [PT_W-1:0]    lo,
                                          input logic signed [PT_W-1:0]    hi,
                                          input logic signed [TOTAL_W-1:0] total,
                                          input logic [COUNT_W-1:0]        n,
                                          input logic [REG_W-1:0]          org,
                                          input logic [REG_W-1:0]          extent);
      longint unit, spread, span, centre2, diff;
      unit    = longint'(1) << FRAC_BITS;
      spread  = longint'(hi) - longint'(lo);
      span    = longint'(extent) * unit;
      centre2 = longint'(n) * (2 * longint'(org) + longint'(extent)) * unit;
      diff    = 2 * longint'(total) - centre2;
      if (diff < 0) begin
         diff = -diff;
      end
      return (2 * spread <= 3 * span) && (diff <= longint'(n) * span);
   endfunction

   // Fold one accepted point into the running state; a last point yields a
   // verdict and clears the state for the next shape.
   task automatic absorb_landmark(input logic signed [PT_W-1:0] x,
                                  input logic signed [PT_W-1:0] y,
                                  input logic                   last);
      bit fits;
      if (x > hi_x) hi_x = x;
      if (x < lo_x) lo_x = x;
      if (y > hi_y) hi_y = y;
      if (y < lo_y) lo_y = y;
      // past the bound, extremes still move but sums and count freeze
      if (pts_held < MAX_PTS) begin
         tot_x    = tot_x + x;
         tot_y    = tot_y + y;
         pts_held = pts_held + 1'b1;
      end
      if (last) begin
         fits = axis_within_box(lo_x, hi_x, tot_x, pts_held, box_now.left, box_now.width)
             && axis_within_box(lo_y, hi_y, tot_y, pts_held, box_now.top, box_now.height);
         fit_verdicts_due = {fit_verdicts_due, fits};
         hi_x     = PT_MOST_NEG;
         lo_x     = PT_MOST_POS;
         hi_y     = PT_MOST_NEG;
         lo_y     = PT_MOST_POS;
         tot_x    = '0;
         tot_y    = '0;
         pts_held = '0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitors, sampled at the rising edge
   // ------------------------------------------------------------------------

   // point beats feed the predictor
   always @(posedge clock) begin
      point_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         points_accepted++;
         absorb_landmark(req_point_x, req_point_y, req_last_point);
      end
   end

   // register writes update the predicted bank
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_BOX_LEFT:   box_now.left   = csr_data;
            REG_BOX_TOP:    box_now.top    = csr_data;
            REG_BOX_WIDTH:  box_now.width  = csr_data;
            REG_BOX_HEIGHT: box_now.height = csr_data;
            default:        box_now = box_now;
         endcase
      end
   end

   // result beats are scored against the oldest verdict due
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fit_verdicts_due.size() == 0) begin
            $error("shape_inside: no result expected, got %0b", rsp_shape_inside);
            mismatches++;
         end else begin
            want = fit_verdicts_due.pop_front();
            verdicts_checked++;
            inside_seen += want;
            if (rsp_shape_inside !== want) begin
               $error("shape_inside: expected %0b, got %0b", want, rsp_shape_inside);
               mismatches++;
            end
         end
      end
   end

   // watchdog: any beat on any channel counts as progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a beat, %0d verdicts still due",
                  quiet_cycles, fit_verdicts_due.size());
         $display("FAIL shape_in_box_check_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Drivers, updated at the falling edge
   // ------------------------------------------------------------------------

   // point driver: payload holds while stalled; a beat flagged wait_drain is
   // held back until every verdict in flight has come out
   always @(negedge clock) begin
      landmark_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || point_taken) begin
         if (landmarks_pending.size() != 0
             && !(landmarks_pending[0].wait_drain && fit_verdicts_due.size() != 0)
             && $urandom_range(99) >= send_idle_pct) begin
            beat = landmarks_pending.pop_front();
            req_valid      <= 1'b1;
            req_point_x    <= beat.x;
            req_point_y    <= beat.y;
            req_last_point <= beat.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall: random, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic logic signed [PT_W-1:0] to_point(input int v);
      if (v > int'(PT_MOST_POS)) return PT_MOST_POS;
      if (v < int'(PT_MOST_NEG)) return PT_MOST_NEG;
      return PT_W'(v);
   endfunction

   task automatic queue_point(input int x, input int y, input bit last,
                              input bit wait_drain = 1'b0);
      landmark_beat_type beat;
      beat.x          = to_point(x);
      beat.y          = to_point(y);
      beat.last       = last;
      beat.wait_drain = wait_drain;
      landmarks_pending = {landmarks_pending, beat};
   endtask

   // box edges here are whole pixels; points are in 1/2^F pixel units
   task automatic queue_shape(input int n, input bit noisy, input bit pause_first);
      int unit, wx, wy, cx, cy, hx, hy, x, y;
      unit = 1 << FRAC_BITS;
      wx   = int'(box_now.width);
      wy   = int'(box_now.height);
      // centre shifted by up to +-10/16 of the box size, mean tolerance is 8/16
      cx = (2 * int'(box_now.left) + wx) * unit / 2
         + int'($urandom_range(0, 20 * wx)) - 10 * wx;
      cy = (2 * int'(box_now.top) + wy) * unit / 2
         + int'($urandom_range(0, 20 * wy)) - 10 * wy;
      // half-spread from 0.56 to 0.94 of the box size, limit is 0.75
      hx = wx * unit * 3 * int'($urandom_range(6, 10)) / 32;
      hy = wy * unit * 3 * int'($urandom_range(6, 10)) / 32;
      for (int i = 0; i < n; i++) begin
         if (noisy) begin
            x = int'($signed(PT_W'($urandom())));
            y = int'($signed(PT_W'($urandom())));
         end else begin
            x = cx + int'($urandom_range(0, 2 * hx)) - hx;
            y = cy + int'($urandom_range(0, 2 * hy)) - hy;
         end
         queue_point(x, y, i == n - 1, pause_first && i == 0);
      end
   endtask

   task automatic write_box_reg(input reg_index_type idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_box(input int left, input int top, input int width, input int height);
      write_box_reg(REG_BOX_LEFT,   REG_W'(left));
      write_box_reg(REG_BOX_TOP,    REG_W'(top));
      write_box_reg(REG_BOX_WIDTH,  REG_W'(width));
      write_box_reg(REG_BOX_HEIGHT, REG_W'(height));
      box_settings++;
   endtask

   function automatic int pick_extent();
      case ($urandom_range(3))
         0:       return 1;
         1:       return 4095;
         2:       return int'($urandom_range(1, 64));
         default: return int'($urandom_range(1, 4095));
      endcase
   endfunction

   // all points in, all verdicts out, then the pipeline's latency on top
   task automatic wait_for_quiet();
      do @(posedge clock);
      while (landmarks_pending.size() != 0 || req_valid || fit_verdicts_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                   input bit long_hold);
      int queued, shape_no, n;
      write_box(int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
                pick_extent(), pick_extent());
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      queued   = 0;
      shape_no = 0;
      if (long_hold) begin
         hold_request = 1'b1;
         // burst of one-point shapes: enough summaries to back up into the input
         for (int i = 0; i < 8; i++) queue_shape(1, 1'b0, 1'b0);
         queued = 8;
      end
      while (queued < RANDOM_BEATS) begin
         // now and then a shape near or past the point bound
         n = ($urandom_range(39) == 0) ? int'($urandom_range(MAX_PTS - 3, MAX_PTS + 12))
                                       : int'($urandom_range(1, 10));
         // one in five shapes is full-range noise; every twelfth waits for a drain
         queue_shape(n, $urandom_range(4) == 0, shape_no % 12 == 3);
         queued += n;
         shape_no++;
      end
      wait_for_quiet();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset box: 1x1 pixel at the origin, mean must sit in [0,16]
      queue_point(8, 8, 1'b1);
      queue_point(0, 16, 1'b1);
      queue_point(-1, 8, 1'b1);
      queue_point(8, 17, 1'b1);
      queue_point(int'(PT_MOST_NEG), int'(PT_MOST_POS), 1'b1);
      queue_point(int'(PT_MOST_POS), int'(PT_MOST_NEG), 1'b0);
      queue_point(int'(PT_MOST_NEG), int'(PT_MOST_POS), 1'b1);
      wait_for_quiet();

      // box 100,50 size 40x60: centre (1920,1280), spread limits 960 and 1440
      write_box(100, 50, 40, 60);
      queue_point(1920, 1280, 1'b1);
      queue_point(1440, 560, 1'b0);
      queue_point(2400, 2000, 1'b1);      // spread exactly at the limit
      queue_point(1440, 560, 1'b0);
      queue_point(2401, 2000, 1'b1);      // one unit over in x
      queue_point(1600, 1280, 1'b1);      // mean on the left edge
      queue_point(1599, 1280, 1'b1);
      queue_point(1920, 800, 1'b1);       // mean on the top edge
      queue_point(1920, 799, 1'b1);
      queue_point(1920, 1760, 1'b1);      // mean on the bottom edge
      queue_point(1920, 1761, 1'b1);
      // points past the bound: the mean stays on the left edge only if the
      // last two points are left out of the sums
      for (int i = 0; i < MAX_PTS; i++) queue_point(1600, 1280, 1'b0);
      queue_point(700, 1280, 1'b0);
      queue_point(700, 1280, 1'b1);
      wait_for_quiet();

      // zero-sized box: only zero spread with the mean exactly on the edge
      write_box(10, 20, 0, 0);
      queue_point(160, 320, 1'b0);
      queue_point(160, 320, 1'b1);
      queue_point(161, 320, 1'b1);
      queue_point(160, 319, 1'b1);
      wait_for_quiet();

      // largest box: centre 98280, right edge 131040
      write_box(4095, 4095, 4095, 4095);
      queue_point(98280, 98280, 1'b1);
      queue_point(int'(PT_MOST_POS), int'(PT_MOST_POS), 1'b1);
      queue_point(65520, 65520, 1'b0);
      queue_point(131040, 131040, 1'b1);
      wait_for_quiet();

      // random shapes under each idling pattern, two box settings apiece;
      // the first phase also holds the result side off long enough to back
      // the unit up into its point input
      run_random_phase(0, 0, 1'b1);
      run_random_phase(0, 0, 1'b0);
      run_random_phase(49, 0, 1'b0);
      run_random_phase(49, 0, 1'b0);
      run_random_phase(0, 49, 1'b0);
      run_random_phase(0, 49, 1'b0);
      run_random_phase(14, 14, 1'b0);
      run_random_phase(14, 14, 1'b0);

      $display("Run covered %0d point beats over %0d box settings, with and without idling",
               points_accepted, box_settings);
      $display("and a long result hold-off; %0d shape verdicts checked, %0d of them inside.",
               verdicts_checked, inside_seen);
      if (mismatches == 0)
         $display("PASS shape_in_box_check_unit");
      else
         $display("FAIL shape_in_box_check_unit");
      $finish;
   end

endmodule
